>>> sv/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// Types and constants shared by the word tokenizer stream unit.
// ----------------------------------------------------------------------------
package wts_pkg;

  localparam int unsigned QDepth = 4;

  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_ESC,
    MODE_BAR,
    MODE_BAR_ESC,
    MODE_LT,
    MODE_GT
  } mode_e;

  typedef enum logic [2:0] {
    KIND_BYTE,
    KIND_BYTE_END,
    KIND_END,
    KIND_NEWLINE,
    KIND_STREAM
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] tok;
  } res_t;

  // cnt is 1 or 2; r0 leaves first
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> sv/word_tokenizer_stream_unit.sv
// ----------------------------------------------------------------------------
// word_tokenizer_stream_unit
// Byte-stream word tokenizer: raw text bytes in, token bytes with end marks
// out.
// ----------------------------------------------------------------------------
// One input byte is accepted every cycle while the result queue has room.
// Each byte gives zero, one or two results; they pass through the queue and
// leave one per cycle from the output register while the sink takes them.
// A byte with two results holds the output register for each, so a long run
// of such bytes is paced by the output once the QDepth-entry queue is full.
// The queue lets the scan front keep taking bytes while the sink stalls.
module word_tokenizer_stream_unit #(
  parameter int unsigned QDepth = wts_pkg::QDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] end_of_stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] token_byte
  output logic [2:0] m_axis_tuser,   // [2:0] kind
  output logic       m_axis_tlast    // last
);
  import wts_pkg::*;

  logic   push, pop;
  entry_t entry, head;
  qstat_t qstat;
  res_t   out_res;

  wts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .data_i     (s_axis_tdata),
    .eos_i      (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .qstat_i    (qstat),
    .push_o     (push),
    .entry_o    (entry)
  );

  wts_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  wts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = out_res.tok;
  assign m_axis_tuser = out_res.kind;

  a_stream_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_STREAM |-> m_axis_tlast)
    else $error("stream end not marked last");

  a_mark_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_BYTE && m_axis_tuser != KIND_BYTE_END
    |-> m_axis_tdata == 8'h00)
    else $error("end mark carries a byte");

  a_full_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> !s_axis_tready && !qstat.empty)
    else $error("input taken with full queue");

endmodule

>>> sv/wts_front.sv
// ----------------------------------------------------------------------------
// wts_front
// Accepts raw bytes, runs the scan state and packs the one or two results
// of each byte, if it gives any, into a queue entry.
// ----------------------------------------------------------------------------
module wts_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      data_i,
  input  logic            eos_i,
  output logic            in_ready_o,
  input  wts_pkg::qstat_t qstat_i,
  output logic            push_o,
  output wts_pkg::entry_t entry_o
);
  import wts_pkg::*;

  typedef struct packed {
    logic  hit;
    res_t  r;
    mode_e mode;
    logic  ws;
    logic  drop;
  } idle_t;

  mode_e      mode_q, mode_d;
  logic       ws_q, ws_d;
  logic       drop_q, drop_d;
  logic       acc;
  logic [1:0] n;
  res_t       r0, r1;
  idle_t      ib;

  function automatic res_t mk(kind_e k, logic [7:0] b);
    res_t o;
    o.kind = k;
    o.tok  = (k == KIND_BYTE || k == KIND_BYTE_END) ? b : 8'h00;
    return o;
  endfunction

  function automatic logic is_single_op(logic [7:0] c);
    return c == CH_LPAR || c == CH_RPAR || c == CH_LBRK || c == CH_RBRK ||
           c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
           c == CH_EQ || c == CH_HASH;
  endfunction

  function automatic idle_t idle_byte(logic [7:0] c);
    idle_t o;
    o.hit  = 1'b0;
    o.r    = mk(KIND_BYTE, c);
    o.mode = MODE_IDLE;
    o.ws   = 1'b0;
    o.drop = 1'b0;
    if (c == CH_SPACE || c == CH_TAB) begin
      o.mode = MODE_IDLE;
    end else if (c == CH_CR || c == CH_LF) begin
      o.hit  = 1'b1;
      o.r    = mk(KIND_NEWLINE, c);
      o.drop = (c == CH_CR);
    end else if (is_single_op(c)) begin
      o.hit = 1'b1;
      o.r   = mk(KIND_BYTE_END, c);
    end else if (c == CH_LT) begin
      o.mode = MODE_LT;
    end else if (c == CH_GT) begin
      o.mode = MODE_GT;
    end else if (c == CH_BAR) begin
      o.mode = MODE_BAR;
    end else if (c == CH_BSL) begin
      o.mode = MODE_ESC;
    end else begin
      o.hit  = 1'b1;
      o.ws   = 1'b1;
      o.mode = MODE_WORD;
    end
    return o;
  endfunction

  assign in_ready_o = !qstat_i.full;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    ib     = idle_byte(data_i);
    n      = 2'd0;
    r0     = ib.r;
    r1     = ib.r;
    mode_d = mode_q;
    ws_d   = ws_q;
    drop_d = drop_q;
    if (eos_i) begin
      mode_d = MODE_IDLE;
      ws_d   = 1'b0;
      drop_d = 1'b0;
      r1     = mk(KIND_STREAM, 8'h00);
      n      = 2'd2;
      if (mode_q == MODE_LT) begin
        r0 = mk(KIND_BYTE_END, CH_LT);
      end else if (mode_q == MODE_GT) begin
        r0 = mk(KIND_BYTE_END, CH_GT);
      end else if (mode_q != MODE_IDLE && ws_q) begin
        r0 = mk(KIND_END, 8'h00);
      end else begin
        r0 = mk(KIND_STREAM, 8'h00);
        n  = 2'd1;
      end
    end else begin
      drop_d = 1'b0;
      if (!(drop_q && data_i == CH_LF)) begin
        unique case (mode_q)
          MODE_WORD: begin
            if (data_i == CH_SPACE || data_i == CH_TAB) begin
              n      = 2'd1;
              r0     = mk(KIND_END, 8'h00);
              mode_d = MODE_IDLE;
              ws_d   = 1'b0;
            end else if (data_i == CH_CR || data_i == CH_LF || data_i == CH_LPAR ||
                         data_i == CH_RPAR || data_i == CH_LBRK || data_i == CH_RBRK) begin
              r0     = mk(KIND_END, 8'h00);
              r1     = ib.r;
              n      = ib.hit ? 2'd2 : 2'd1;
              mode_d = ib.mode;
              ws_d   = ib.ws;
              drop_d = ib.drop;
            end else if (data_i == CH_BAR) begin
              mode_d = MODE_BAR;
            end else if (data_i == CH_BSL) begin
              mode_d = MODE_ESC;
            end else begin
              n  = 2'd1;
              r0 = mk(KIND_BYTE, data_i);
            end
          end
          MODE_ESC: begin
            n      = 2'd1;
            r0     = mk(KIND_BYTE, data_i);
            ws_d   = 1'b1;
            mode_d = MODE_WORD;
          end
          MODE_BAR: begin
            if (data_i == CH_BAR) begin
              mode_d = ws_q ? MODE_WORD : MODE_IDLE;
            end else if (data_i == CH_BSL) begin
              mode_d = MODE_BAR_ESC;
            end else begin
              n    = 2'd1;
              r0   = mk(KIND_BYTE, data_i);
              ws_d = 1'b1;
            end
          end
          MODE_BAR_ESC: begin
            n      = 2'd1;
            r0     = mk(KIND_BYTE, data_i);
            ws_d   = 1'b1;
            mode_d = MODE_BAR;
          end
          MODE_LT, MODE_GT: begin
            if ((mode_q == MODE_LT && data_i == CH_GT) || data_i == CH_EQ) begin
              n      = 2'd2;
              r0     = mk(KIND_BYTE, (mode_q == MODE_LT) ? CH_LT : CH_GT);
              r1     = mk(KIND_BYTE_END, data_i);
              mode_d = MODE_IDLE;
              ws_d   = 1'b0;
            end else begin
              r0     = mk(KIND_BYTE_END, (mode_q == MODE_LT) ? CH_LT : CH_GT);
              r1     = ib.r;
              n      = ib.hit ? 2'd2 : 2'd1;
              mode_d = ib.mode;
              ws_d   = ib.ws;
              drop_d = ib.drop;
            end
          end
          default: begin
            r0     = ib.r;
            n      = ib.hit ? 2'd1 : 2'd0;
            mode_d = ib.mode;
            ws_d   = ib.ws;
            drop_d = ib.drop;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      ws_q   <= 1'b0;
      drop_q <= 1'b0;
    end else if (acc) begin
      mode_q <= mode_d;
      ws_q   <= ws_d;
      drop_q <= drop_d;
    end
  end

  assign push_o      = acc && (n != 2'd0);
  assign entry_o.cnt = n;
  assign entry_o.r0  = r0;
  assign entry_o.r1  = r1;

endmodule

>>> sv/wts_queue.sv
// ----------------------------------------------------------------------------
// wts_queue
// Short FIFO of result entries between the front and the back.
// ----------------------------------------------------------------------------
module wts_queue #(
  parameter int unsigned Depth = wts_pkg::QDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wts_pkg::entry_t entry_i,
  input  logic            pop_i,
  output wts_pkg::entry_t head_o,
  output wts_pkg::qstat_t qstat_o
);
  import wts_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign qstat_o.full  = (cnt_q == CntFull);
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == PtrLast) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? ((rd_q == PtrLast) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

>>> sv/wts_back.sv
// ----------------------------------------------------------------------------
// wts_back
// Takes queue entries apart into single results and holds them in the
// output register until the sink takes them.
// ----------------------------------------------------------------------------
module wts_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wts_pkg::entry_t head_i,
  input  wts_pkg::qstat_t qstat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output wts_pkg::res_t   out_res_o,
  output logic            out_last_o
);
  import wts_pkg::*;

  logic sel_q, sel_d;
  logic valid_q, valid_d;
  res_t res_q, res_d;
  logic last_q, last_d;
  logic load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    sel_d   = sel_q;
    valid_d = valid_q;
    res_d   = res_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !qstat_i.empty;
      if (!qstat_i.empty) begin
        res_d  = sel_q ? head_i.r1 : head_i.r0;
        last_d = sel_q || (head_i.cnt == 2'd1);
        pop_o  = last_d;
        sel_d  = !last_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      sel_q   <= sel_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;
  assign out_last_o  = last_q;

endmodule
